// File: rtl/core/lru_page_map_top_macros.svh
// Assertion macros shared by the checker of the LRU page map.
// No dependencies; include by bare file name.
`ifndef LRU_PAGE_MAP_TOP_MACROS_SVH
`define LRU_PAGE_MAP_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_page_map_top: check failed");

// Next-cycle implication, masked during reset.
`define LPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_page_map_top: check failed");

// Next-cycle implication that also holds across reset.
`define LPM_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lru_page_map_top: check failed");

`endif

// File: rtl/core/lpm_pkg.sv
// Package for the LRU page map: field widths, request and status codes,
// and the request/response structs. No dependencies.
package lpm_pkg;

  localparam int MODE_W   = 2;
  localparam int PAGE_W   = 64;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVICT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_in;
  } lpm_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_out;
    logic [PAGE_W-1:0]   victim_page;
  } lpm_rsp_t;

endpackage

// File: rtl/core/lpm_entry_array.sv
// Associative entry array of the LRU page map: tags, frames, recency ranks,
// parallel match and registered update on each fire. Depends on lpm_pkg.
module lpm_entry_array #(
  parameter int ENTRIES    = 64,
  parameter int FRAME_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lpm_pkg::lpm_req_t req,
  output lpm_pkg::lpm_rsp_t rsp
);

  localparam int RW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int FSW = (FRAME_BITS < lpm_pkg::FRAME_W) ? FRAME_BITS : lpm_pkg::FRAME_W;

  logic [ENTRIES-1:0]          valid_r, valid_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [lpm_pkg::PAGE_W-1:0]  tag_r   [ENTRIES];
  logic [lpm_pkg::PAGE_W-1:0]  tag_nxt [ENTRIES];
  logic [FSW-1:0]              frame_r   [ENTRIES];
  logic [FSW-1:0]              frame_nxt [ENTRIES];
  logic [RW-1:0]               rank_r   [ENTRIES];
  logic [RW-1:0]               rank_nxt [ENTRIES];

  logic [ENTRIES-1:0]          hit_vec, evict_vec, free_vec;
  logic                        hit, found, full;
  logic [RW-1:0]               hit_rank, last_rank;
  logic [CW-1:0]               cnt_m1;
  logic [FSW-1:0]              hit_frame, evict_frame, new_frame;
  logic [lpm_pkg::PAGE_W-1:0]  evict_tag;

  assign new_frame = req.frame_in[FSW-1:0];
  assign cnt_m1    = count_r - CW'(1);
  assign last_rank = cnt_m1[RW-1:0];
  assign full      = (count_r == CW'(ENTRIES));
  // lowest free slot as a one-hot vector
  assign free_vec  = ~valid_r & (valid_r + {{(ENTRIES-1){1'b0}}, 1'b1});

  // Tags of valid entries are unique and their ranks form a permutation,
  // so each match vector is at most one-hot and an OR merges the fields.
  always_comb begin
    hit_rank    = '0;
    hit_frame   = '0;
    evict_frame = '0;
    evict_tag   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (tag_r[i] == req.page_number);
      evict_vec[i] = valid_r[i] && (rank_r[i] == last_rank);
      hit_rank     = hit_rank    | (hit_vec[i]   ? rank_r[i]  : '0);
      hit_frame    = hit_frame   | (hit_vec[i]   ? frame_r[i] : '0);
      evict_frame  = evict_frame | (evict_vec[i] ? frame_r[i] : '0);
      evict_tag    = evict_tag   | (evict_vec[i] ? tag_r[i]   : '0);
    end
    hit   = |hit_vec;
    found = |evict_vec;
  end

  always_comb begin
    valid_nxt       = valid_r;
    count_nxt       = count_r;
    rsp.status      = lpm_pkg::ST_OK;
    rsp.frame_out   = '0;
    rsp.victim_page = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_nxt[i]   = tag_r[i];
      frame_nxt[i] = frame_r[i];
      rank_nxt[i]  = rank_r[i];
    end
    case (req.mode)
      lpm_pkg::MODE_LOOKUP: begin
        if (hit) begin
          rsp.frame_out = lpm_pkg::FRAME_W'(hit_frame);
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
              rank_nxt[i] = '0;
            end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
              rank_nxt[i] = rank_r[i] + RW'(1);
            end
          end
        end else begin
          rsp.status = lpm_pkg::ST_MISS;
        end
      end
      lpm_pkg::MODE_INSERT: begin
        if (hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
              rank_nxt[i]  = '0;
              frame_nxt[i] = new_frame;
            end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
              rank_nxt[i] = rank_r[i] + RW'(1);
            end
          end
        end else if (full) begin
          rsp.status = lpm_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          for (int i = 0; i < ENTRIES; i++) begin
            if (free_vec[i]) begin
              valid_nxt[i] = 1'b1;
              tag_nxt[i]   = req.page_number;
              frame_nxt[i] = new_frame;
              rank_nxt[i]  = '0;
            end else if (valid_r[i]) begin
              rank_nxt[i] = rank_r[i] + RW'(1);
            end
          end
        end
      end
      lpm_pkg::MODE_EVICT: begin
        if (found) begin
          rsp.frame_out   = lpm_pkg::FRAME_W'(evict_frame);
          rsp.victim_page = evict_tag;
          valid_nxt       = valid_r & ~evict_vec;
          count_nxt       = cnt_m1;
        end else begin
          rsp.status = lpm_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (fire) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_r[i]   <= tag_nxt[i];
        frame_r[i] <= frame_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

endmodule

// File: rtl/core/lru_page_map_top.sv
// LRU page map: top level with input register, entry array and result
// register. Depends on lpm_pkg and lpm_entry_array.
//
// Usage:
//   Requests arrive on the in_ stream: in_tuser carries the request kind
//   (lookup, insert or update, evict least recent), in_tdata the page number
//   and the frame. Each request yields exactly one transaction on the out_
//   stream: out_tuser carries the status, out_tdata the frame and the
//   victim page (zero where they do not apply).
//   Timing: an accepted request waits in the input register until the result
//   register, which drives out_tvalid, can advance. Throughput: one request
//   per cycle while out_tready is high. The whole tag compare, rank update
//   and result selection sit between the input register and the result
//   register; the entry array updates in the cycle the result is latched.
//   Stall: while out_tvalid is high and out_tready low, the result register
//   holds and the input register takes one more request if it is empty;
//   then in_tready drops until the receiver takes the waiting result.
//   Reset (rst_n low, synchronous): empty the table (all entries invalid,
//   count zero) and drop any request in flight. Tags, frames and ranks are
//   not cleared; they are written before they are used.
module lru_page_map_top #(
  parameter int ENTRIES    = 64,
  parameter int FRAME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // [63:0] page_number, [79:64] frame_in
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [15:0] frame_out, [79:16] victim_page
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic              req_valid_r;
  lpm_pkg::lpm_req_t req_r;
  logic              out_valid_r;
  lpm_pkg::lpm_rsp_t rsp_r;
  lpm_pkg::lpm_rsp_t rsp;
  logic              advance;
  logic              fire;

  // Result register can take a new value when empty or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = req_valid_r && advance;
  assign in_tready = !req_valid_r || advance;

  // Input register: capture each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.mode        <= in_tuser;
      req_r.page_number <= in_tdata[63:0];
      req_r.frame_in    <= in_tdata[79:64];
    end
  end

  lpm_entry_array #(
    .ENTRIES    (ENTRIES),
    .FRAME_BITS (FRAME_BITS)
  ) u_entry_array (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req_r),
    .rsp   (rsp)
  );

  // Result register: advance when the receiver is free, hold otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rsp_r.status;
  assign out_tdata  = {rsp_r.victim_page, rsp_r.frame_out};

endmodule

// File: rtl/core/lpm_checker.sv
// Port-level checker for lru_page_map_top and its bind.
// Depends on lpm_pkg and lru_page_map_top_macros.svh.
`include "lru_page_map_top_macros.svh"

module lpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [79:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A waiting request holds its payload until taken.
  `LPM_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready,
                   in_tvalid && $stable(in_tdata) && $stable(in_tuser))

  // A stalled result holds its payload.
  `LPM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Reset drops any pending result.
  `LPM_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)

  // A miss or a dropped insert carries no frame and no victim.
  `LPM_ASSERT_NOW(a_miss_full_zero,
                  out_tvalid && ((out_tuser == lpm_pkg::ST_MISS) ||
                                 (out_tuser == lpm_pkg::ST_FULL)),
                  out_tdata == 80'd0)

  // An evict on an empty table carries no frame and no victim.
  `LPM_ASSERT_NOW(a_empty_zero, out_tvalid && (out_tuser == lpm_pkg::ST_EMPTY),
                  out_tdata == 80'd0)

endmodule

bind lru_page_map_top lpm_checker u_lpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
